FILE: hdl/sdaa_pkg.sv
// Shared constants for the signed binary to decimal ASCII unit.
// No dependencies; imported by sdaa_dabble and the top level.
`timescale 1ns / 1ps
`default_nettype none

package sdaa_pkg;

	// Width of the input transfer payload and of one output character
	localparam int DATA_W  = 32;
	localparam int CHAR_W  = 8;
	localparam int DIGIT_W = 4;

	// ASCII codes
	localparam logic [CHAR_W-1:0] ASCII_ZERO  = 8'h30;
	localparam logic [CHAR_W-1:0] ASCII_NINE  = 8'h39;
	localparam logic [CHAR_W-1:0] ASCII_MINUS = 8'h2D;

	// Double dabble correction: digits at or above this get ADJ_ADD before the shift
	localparam logic [DIGIT_W-1:0] ADJ_LIMIT = 4'd5;
	localparam logic [DIGIT_W-1:0] ADJ_ADD   = 4'd3;

endpackage : sdaa_pkg

`default_nettype wire

FILE: hdl/sdaa_dabble.sv
// Iterative double dabble unit: one magnitude bit shifted into the BCD register per cycle.
// Depends on sdaa_pkg for the digit width and correction constants.
`timescale 1ns / 1ps
`default_nettype none

module sdaa_dabble
	import sdaa_pkg::*;
#(
	parameter int MAG_W = 32,
	parameter int NDIG  = 10
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      start,
	input  wire logic [MAG_W-1:0]          mag,
	output logic                           done,
	output logic [NDIG*DIGIT_W-1:0]        bcd
);

	localparam int CNT_W = $clog2(MAG_W);
	localparam int BCD_W = NDIG * DIGIT_W;

	logic [MAG_W-1:0] shift_q;
	logic [BCD_W-1:0] bcd_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [BCD_W-1:0] adj;

	// Correct every digit that would overflow on the next doubling
	always_comb begin
		for (int k = 0; k < NDIG; k++) begin
			if (bcd_q[k*DIGIT_W +: DIGIT_W] >= ADJ_LIMIT) begin
				adj[k*DIGIT_W +: DIGIT_W] = bcd_q[k*DIGIT_W +: DIGIT_W] + ADJ_ADD;
			end else begin
				adj[k*DIGIT_W +: DIGIT_W] = bcd_q[k*DIGIT_W +: DIGIT_W];
			end
		end
	end

	// Sequencer: load on start, then shift one bit per cycle until all MAG_W bits are in
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(MAG_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath: binary shifter and BCD accumulator
	always_ff @(posedge clk) begin
		if (start) begin
			shift_q <= mag;
			bcd_q   <= '0;
		end else if (busy_q) begin
			shift_q <= {shift_q[MAG_W-2:0], 1'b0};
			bcd_q   <= {adj[BCD_W-2:0], shift_q[MAG_W-1]};
		end
	end

	assign done = done_q;
	assign bcd  = bcd_q;

endmodule : sdaa_dabble

`default_nettype wire

FILE: hdl/signed_binary_to_decimal_ascii_unit.sv
// Top level of the signed binary to decimal ASCII unit: input stage, sequencer, character output.
// Depends on sdaa_pkg and sdaa_dabble.
//
// Usage:
//   Slave channel (s_tvalid/s_tready/s_tdata) takes one signed integer per transfer;
//   only the low VALUE_BITS bits are used, bit VALUE_BITS-1 is the sign.
//   Master channel (m_tvalid/m_tready/m_tdata/m_tlast) gives the decimal text,
//   most significant character first: an optional '-', then the digits without
//   leading zeros ('0' for zero). m_tlast marks the final character of the run.
//   Timing: after a transfer is accepted the double dabble unit shifts in one
//   magnitude bit per cycle, its done flag is registered, the sequencer then picks
//   the leading digit, and characters leave at one per cycle while m_tready allows.
//   The next item can be accepted once the final character has been loaded into
//   the output register.
//   s_tready is high only between items; the next item may be taken while the
//   final character still waits in the output register.
//   Receiver stall: the output register holds its character while m_tready is low
//   and the sequencer waits. Reset empties the output register and returns the
//   sequencer to idle; no other state is kept between items.
`timescale 1ns / 1ps
`default_nettype none

module signed_binary_to_decimal_ascii_unit
	import sdaa_pkg::*;
#(
	parameter int VALUE_BITS = 32
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              s_tvalid,
	output logic                   s_tready,
	input  wire logic [DATA_W-1:0] s_tdata,   // [31:0] value
	output logic                   m_tvalid,
	input  wire logic              m_tready,
	output logic [CHAR_W-1:0]      m_tdata,   // [7:0] character
	output logic                   m_tlast
);

	localparam int NDIG  = ((VALUE_BITS - 1) * 302) / 1000 + 1;
	localparam int IDX_W = $clog2(NDIG);
	localparam int BCD_W = NDIG * DIGIT_W;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_CONV = 2'd1;
	localparam logic [1:0] ST_LEAD = 2'd2;
	localparam logic [1:0] ST_EMIT = 2'd3;

	logic [1:0]            state_q;
	logic                  neg_q;
	logic                  minus_q;
	logic [IDX_W-1:0]      idx_q;
	logic                  m_tvalid_q;
	logic [CHAR_W-1:0]     char_q;
	logic                  last_q;

	logic                  in_xfer;
	logic                  load;
	logic [VALUE_BITS-1:0] raw;
	logic [VALUE_BITS-1:0] mag;
	logic                  dab_done;
	logic [BCD_W-1:0]      bcd;
	logic [IDX_W-1:0]      lead;
	logic [DIGIT_W-1:0]    digit;

	// Magnitude of the input; the most negative value wraps onto its own unsigned magnitude
	assign raw     = s_tdata[VALUE_BITS-1:0];
	assign mag     = raw[VALUE_BITS-1] ? (~raw + 1'b1) : raw;
	assign s_tready = (state_q == ST_IDLE);
	assign in_xfer  = s_tvalid && s_tready;

	sdaa_dabble #(
		.MAG_W (VALUE_BITS),
		.NDIG  (NDIG)
	) u_dabble (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (in_xfer),
		.mag    (mag),
		.done   (dab_done),
		.bcd    (bcd)
	);

	// Find the highest nonzero digit; zero falls back to the lowest digit
	always_comb begin
		lead = '0;
		for (int k = 0; k < NDIG; k++) begin
			if (bcd[k*DIGIT_W +: DIGIT_W] != '0) begin
				lead = IDX_W'(k);
			end
		end
	end

	assign digit = bcd[idx_q*DIGIT_W +: DIGIT_W];
	assign load  = (state_q == ST_EMIT) && (!m_tvalid_q || m_tready);

	// Sequencer: accept, convert, locate leading digit, emit characters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			neg_q   <= 1'b0;
			minus_q <= 1'b0;
			idx_q   <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_xfer) begin
						neg_q   <= raw[VALUE_BITS-1];
						state_q <= ST_CONV;
					end
				end
				ST_CONV: begin
					if (dab_done) begin
						state_q <= ST_LEAD;
					end
				end
				ST_LEAD: begin
					idx_q   <= lead;
					minus_q <= neg_q;
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (load) begin
						if (minus_q) begin
							minus_q <= 1'b0;
						end else if (idx_q == '0) begin
							state_q <= ST_IDLE;
						end else begin
							idx_q <= idx_q - 1'b1;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Output register valid: set on load, drop once the transfer completes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (load) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	// Output register payload: minus sign first, then digits
	always_ff @(posedge clk) begin
		if (load) begin
			if (minus_q) begin
				char_q <= ASCII_MINUS;
				last_q <= 1'b0;
			end else begin
				char_q <= ASCII_ZERO + {{(CHAR_W-DIGIT_W){1'b0}}, digit};
				last_q <= (idx_q == '0);
			end
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = char_q;
	assign m_tlast  = last_q;

	// Conversion finishes only while the sequencer waits for it
	a_done_in_conv: assert property (@(posedge clk) disable iff (!arst_n)
		dab_done |-> (state_q == ST_CONV))
		else $error("dabble done outside conversion");

	// An accepted item always starts a conversion
	a_accept_conv: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer |=> (state_q == ST_CONV))
		else $error("accepted item did not start conversion");

	// Only a minus sign or a decimal digit leaves the block
	a_char_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata == ASCII_MINUS ||
			(m_tdata >= ASCII_ZERO && m_tdata <= ASCII_NINE)))
		else $error("output character out of range");

	// A minus sign never ends a run
	a_minus_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tdata == ASCII_MINUS) |-> !m_tlast)
		else $error("minus sign flagged as last");

	// The digit index does not move during conversion
	a_idx_stable: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CONV) |=> $stable(idx_q))
		else $error("digit index moved during conversion");

endmodule : signed_binary_to_decimal_ascii_unit

`default_nettype wire

FILE: tb/tb_signed_binary_to_decimal_ascii_unit.sv
// Self-checking testbench for signed_binary_to_decimal_ascii_unit: drives signed integers
// with bursty gaps, predicts each decimal character run, and checks every output transfer.
// Depends on sdaa_pkg and the unit's RTL.
`timescale 1ns / 1ps

module tb_signed_binary_to_decimal_ascii_unit;
	import sdaa_pkg::*;

	localparam int VALUE_BITS  = 32;
	localparam int CYCLE_LIMIT = 600000;
	localparam int DRAIN_WAIT  = 60;

	typedef struct packed {
		logic [CHAR_W-1:0] code;
		logic              last;
	} text_char_t;

	// Receiver back-pressure patterns
	typedef enum logic [1:0] {
		RX_ALWAYS,
		RX_RANDOM,
		RX_WINDOW,
		RX_SPARSE
	} rx_mode_e;

	logic              clk      = 1'b0;
	logic              arst_n   = 1'b0;
	logic              s_tvalid = 1'b0;
	logic              s_tready;
	logic [DATA_W-1:0] s_tdata  = '0;   // [31:0] value
	logic              m_tvalid;
	logic              m_tready = 1'b0;
	logic [CHAR_W-1:0] m_tdata;         // [7:0] character
	logic              m_tlast;

	text_char_t pending_chars[$];
	rx_mode_e   rx_mode  = RX_ALWAYS;
	logic [7:0] rx_phase = '0;
	int         burst_left   = 0;
	int         gap_max      = 0;
	int         cycle_count  = 0;
	int         mismatches   = 0;
	int         values_sent  = 0;
	int         negatives    = 0;
	int         chars_seen   = 0;

	signed_binary_to_decimal_ascii_unit #(
		.VALUE_BITS(VALUE_BITS)
	) dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tlast (m_tlast)
	);

	always #5 clk = ~clk;

	// Count cycles and stop a hung run
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d characters outstanding", cycle_count,
				pending_chars.size());
			$display("end of test: mismatches");
			$finish;
		end
	end

	// Drive receiver readiness on the selected pattern
	always @(posedge clk) begin
		rx_phase <= rx_phase + 8'd1;
		case (rx_mode)
			RX_ALWAYS: m_tready <= 1'b1;
			RX_RANDOM: m_tready <= ($urandom_range(0, 3) != 0);
			RX_WINDOW: m_tready <= ((rx_phase % 13) < 5);
			default:   m_tready <= ($urandom_range(0, 4) == 0);
		endcase
	end

	task automatic report_mismatch(input string what);
		mismatches++;
		if (mismatches <= 40)
			$display("mismatch at cycle %0d: %s", cycle_count, what);
	endtask

	// Build the expected character run of one value: optional minus, then digits
	function automatic void queue_decimal_text(input logic [DATA_W-1:0] word);
		logic [VALUE_BITS-1:0] raw;
		logic [VALUE_BITS:0]   magnitude;
		logic [CHAR_W-1:0]     digits[$];
		text_char_t            entry;
		raw       = word[VALUE_BITS-1:0];
		magnitude = {1'b0, raw};
		// widen before negating so the most negative value keeps its magnitude
		if (raw[VALUE_BITS-1])
			magnitude = {1'b1, {VALUE_BITS{1'b0}}} - magnitude;
		do begin
			digits.push_front(ASCII_ZERO + CHAR_W'(magnitude % 10));
			magnitude = magnitude / 10;
		end while (magnitude != 0);
		if (raw[VALUE_BITS-1]) begin
			entry.code = ASCII_MINUS;
			entry.last = 1'b0;
			pending_chars.push_back(entry);
			negatives++;
		end
		foreach (digits[i]) begin
			entry.code = digits[i];
			entry.last = (i == digits.size() - 1);
			pending_chars.push_back(entry);
		end
	endfunction

	// Check each output transfer against the oldest expected character
	always @(posedge clk) begin
		text_char_t want;
		if (arst_n && m_tvalid && m_tready) begin
			chars_seen++;
			if (pending_chars.size() == 0) begin
				report_mismatch($sformatf("unexpected character 0x%02h last=%b", m_tdata,
					m_tlast));
			end else begin
				want = pending_chars.pop_front();
				if (m_tdata !== want.code)
					report_mismatch($sformatf("character 0x%02h, expected 0x%02h", m_tdata,
						want.code));
				if (m_tlast !== want.last)
					report_mismatch($sformatf("last %b on 0x%02h, expected %b", m_tlast,
						m_tdata, want.last));
			end
		end
	end

	// Send one value; idle between bursts when gaps are enabled
	task automatic send_value(input logic [DATA_W-1:0] word);
		int gap;
		if (burst_left == 0 && gap_max > 0) begin
			gap = $urandom_range(1, gap_max);
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
			burst_left = $urandom_range(1, 8);
		end
		s_tdata  <= word;
		s_tvalid <= 1'b1;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		queue_decimal_text(word);
		values_sent++;
		if (burst_left > 0)
			burst_left--;
	endtask

	// Mix of full-range, small, mid-size and power-of-ten neighbor values
	function automatic logic [DATA_W-1:0] pick_value();
		int v;
		int p;
		int k;
		case ($urandom_range(0, 3))
			0: return $urandom;
			1: v = $urandom_range(0, 99);
			2: v = $urandom_range(0, 999999);
			default: begin
				p = 1;
				k = $urandom_range(0, 9);
				repeat (k) p = p * 10;
				v = p + $urandom_range(0, 2) - 1;
			end
		endcase
		if ($urandom_range(0, 1))
			v = -v;
		return v;
	endfunction

	// Zero, the extremes, single digits, inner zeros and every digit code
	task automatic test_special_values();
		int values[] = '{0, 1, -1, 9, -9, 10, -10, 99, 100, -100, 2147483647,
			-2147483648, -2147483647, 1000000000, -1000000000, 999999999, 2000000001,
			1234567890, -987654321, 5, -505050505};
		rx_mode = RX_ALWAYS;
		gap_max = 0;
		foreach (values[i])
			send_value(values[i]);
	endtask

	// Heavy receiver back-pressure with long sender gaps
	task automatic test_back_pressure();
		rx_mode = RX_SPARSE;
		gap_max = 50;
		repeat (60)
			send_value(pick_value());
	endtask

	// Random values with a receiver pattern and gap length picked at random every 40 values
	task automatic test_random_values();
		for (int i = 0; i < 300; i++) begin
			if (i % 40 == 0) begin
				rx_mode = rx_mode_e'($urandom_range(0, 3));
				case ($urandom_range(0, 3))
					0:       gap_max = 0;
					1:       gap_max = 3;
					2:       gap_max = 12;
					default: gap_max = 60;
				endcase
			end
			send_value(pick_value());
		end
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_special_values();
		test_back_pressure();
		test_random_values();
		s_tvalid <= 1'b0;
		rx_mode = RX_RANDOM;
		while (pending_chars.size() != 0) @(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
		$display("converted %0d values (%0d negative), checked %0d characters",
			values_sent, negatives, chars_seen);
		$display("covered extremes, zero, digit boundaries and four back-pressure patterns");
		if (mismatches == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
